@@ rtl/rc4_pkg.sv @@
// rc4 stream cipher package: sizes, register map and sequencer states
// no dependencies; used by every other file of the block

package rc4_pkg;

  localparam int unsigned KEY_BYTES_DEF = 6;
  localparam int unsigned KEY_BYTES_MAX = 8;
  localparam int unsigned KEY_W         = 48;
  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned ADDR_W        = $clog2(TABLE_DEPTH);

  // apb map: one 64-bit register, eight bytes per slot
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;
  localparam int unsigned REG_IDX_LSB = 3;

  typedef enum logic {
    REG_CIPHER_KEY = 1'b0
  } reg_idx_e;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [KEY_W-1:0]  key_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_RDN,
    ST_MIX_RDA,
    ST_MIX_WRN,
    ST_MIX_WRA,
    ST_KS_I,
    ST_KS_J,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_OUT
  } state_e;

endpackage

@@ rtl/rc4_ifs.sv @@
// valid/ready channel interfaces for the rc4 stream cipher
// depends on rc4_pkg for the byte type

interface rc4_in_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t plain_byte;
  logic           last_byte;

  modport source (output valid, output plain_byte, output last_byte, input ready);
  modport sink   (input valid, input plain_byte, input last_byte, output ready);
endinterface

interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink   (input valid, input cipher_byte, output ready);
endinterface

@@ rtl/rc4_key_regs.sv @@
// apb register slice holding the cipher key
// depends on rc4_pkg for the register map

module rc4_key_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rc4_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rc4_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rc4_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output rc4_pkg::key_t                     key_o
);

  rc4_pkg::key_t key_q, key_d;
  logic          sel_key;
  logic          wr_en;

  assign sel_key = (paddr[rc4_pkg::APB_ADDR_W-1:rc4_pkg::REG_IDX_LSB]
                    == rc4_pkg::REG_CIPHER_KEY);
  assign wr_en   = psel && penable && pwrite && sel_key;
  assign pready  = 1'b1;

  always_comb begin
    key_d = key_q;
    if (wr_en) begin
      key_d = pwdata[rc4_pkg::KEY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_key) begin
      prdata = {{(rc4_pkg::APB_DATA_W-rc4_pkg::KEY_W){1'b0}}, key_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

@@ rtl/rc4_engine.sv @@
// rc4 sequencer around a 256-entry permutation memory (registered read)
// runs key scheduling and keystream steps; holds the output register
// depends on rc4_pkg and rc4_ifs

module rc4_engine #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rc4_pkg::key_t key_i,
  rc4_in_if.sink        in_i,
  rc4_out_if.source     out_o
);

  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned AW     = rc4_pkg::ADDR_W;
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);
  localparam logic [AW-1:0]     N_LAST    = AW'(rc4_pkg::TABLE_DEPTH - 1);

  // permutation memory
  rc4_pkg::byte_t mem [rc4_pkg::TABLE_DEPTH];
  rc4_pkg::byte_t rdata_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  rc4_pkg::byte_t mem_wdata;

  rc4_pkg::state_e state_q, state_d;
  logic [AW-1:0]     i_q, i_d, j_q, j_d, n_q, n_d, acc_q, acc_d;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  rc4_pkg::byte_t    si_q, si_d, plain_q, plain_d, cipher_q, cipher_d;
  logic              fwd_q, fwd_d, rekey_q, rekey_d, ov_q, ov_d;

  logic              in_fire, load_out;
  logic [rc4_pkg::KEY_BYTES_MAX-1:0][rc4_pkg::BYTE_W-1:0] key_pad;
  rc4_pkg::byte_t    key_byte, ks_byte;
  logic [AW-1:0]     t_addr, acc_next;

  assign in_i.ready = (state_q == rc4_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_out   = (state_q == rc4_pkg::ST_OUT) && (!ov_q || out_o.ready);

  // key bytes beyond the register read as zero
  assign key_pad  = {{(rc4_pkg::KEY_BYTES_MAX*rc4_pkg::BYTE_W-rc4_pkg::KEY_W){1'b0}}, key_i};
  assign key_byte = key_pad[3'(kidx_q)];
  assign acc_next = acc_q + rdata_q + key_byte;
  assign t_addr   = si_q + rdata_q;
  // S[t] read in the cycle S[j] is written: memory returns old data there
  assign ks_byte  = fwd_q ? si_q : rdata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = rekey_q ? rc4_pkg::ST_FILL : rc4_pkg::ST_KS_J;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (n_q == N_LAST) begin
          state_d = rc4_pkg::ST_MIX_RDN;
        end
      end
      rc4_pkg::ST_MIX_RDN: state_d = rc4_pkg::ST_MIX_RDA;
      rc4_pkg::ST_MIX_RDA: state_d = rc4_pkg::ST_MIX_WRN;
      rc4_pkg::ST_MIX_WRN: state_d = rc4_pkg::ST_MIX_WRA;
      rc4_pkg::ST_MIX_WRA: begin
        state_d = (n_q == N_LAST) ? rc4_pkg::ST_KS_I : rc4_pkg::ST_MIX_RDN;
      end
      rc4_pkg::ST_KS_I:   state_d = rc4_pkg::ST_KS_J;
      rc4_pkg::ST_KS_J:   state_d = rc4_pkg::ST_SWAP_A;
      rc4_pkg::ST_SWAP_A: state_d = rc4_pkg::ST_SWAP_B;
      rc4_pkg::ST_SWAP_B: state_d = rc4_pkg::ST_OUT;
      rc4_pkg::ST_OUT: begin
        if (load_out) begin
          state_d = rc4_pkg::ST_IDLE;
        end
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  // memory controls and datapath
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = n_q;
    mem_raddr = n_q;
    mem_wdata = rdata_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    acc_d     = acc_q;
    kidx_d    = kidx_q;
    si_d      = si_q;
    fwd_d     = fwd_q;
    plain_d   = plain_q;
    rekey_d   = rekey_q;
    cipher_d  = cipher_q;
    ov_d      = ov_q;
    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_fire) begin
          plain_d = in_i.plain_byte;
          rekey_d = in_i.last_byte;
          n_d     = '0;
          if (!rekey_q) begin
            i_d       = i_q + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = i_q + 1'b1;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = n_q;
        n_d       = n_q + 1'b1;
        acc_d     = '0;
        kidx_d    = '0;
      end
      rc4_pkg::ST_MIX_RDN: begin
        mem_re    = 1'b1;
        mem_raddr = n_q;
      end
      rc4_pkg::ST_MIX_RDA: begin
        si_d      = rdata_q;
        acc_d     = acc_next;
        mem_re    = 1'b1;
        mem_raddr = acc_next;
      end
      rc4_pkg::ST_MIX_WRN: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = rdata_q;
      end
      rc4_pkg::ST_MIX_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = acc_q;
        mem_wdata = si_q;
        n_d       = n_q + 1'b1;
        kidx_d    = (kidx_q == KIDX_LAST) ? '0 : kidx_q + 1'b1;
        i_d       = '0;
        j_d       = '0;
      end
      rc4_pkg::ST_KS_I: begin
        i_d       = i_q + 1'b1;
        mem_re    = 1'b1;
        mem_raddr = i_q + 1'b1;
      end
      rc4_pkg::ST_KS_J: begin
        si_d      = rdata_q;
        j_d       = j_q + rdata_q;
        mem_re    = 1'b1;
        mem_raddr = j_q + rdata_q;
      end
      rc4_pkg::ST_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rdata_q;
      end
      rc4_pkg::ST_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = si_q;
        mem_re    = 1'b1;
        mem_raddr = t_addr;
        fwd_d     = (t_addr == j_q);
      end
      rc4_pkg::ST_OUT: begin
        if (load_out) begin
          cipher_d = plain_q ^ ks_byte;
          ov_d     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      kidx_q  <= '0;
      rekey_q <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_q     <= n_d;
      kidx_q  <= kidx_d;
      rekey_q <= rekey_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    si_q     <= si_d;
    fwd_q    <= fwd_d;
    plain_q  <= plain_d;
    cipher_q <= cipher_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.cipher_byte = cipher_q;

  a_rekey_enters_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && rekey_q) |=> (state_q == rc4_pkg::ST_FILL))
    else $error("rekey item did not start the table fill");

  a_indexes_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_KS_I) |-> (i_q == '0 && j_q == '0))
    else $error("indexes not cleared after key scheduling");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!ov_q || out_o.ready))
    else $error("output register loaded while an item waits");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rc4_pkg::ST_IDLE) |-> !mem_we)
    else $error("permutation memory written while idle");

endmodule

@@ rtl/rc4_stream_cipher.sv @@
// rc4 stream cipher top level: apb key register and the rc4 engine
// depends on rc4_pkg, rc4_ifs, rc4_key_regs and rc4_engine
//
// channel   dir  handshake      payload
// in_i      in   valid/ready    plain_byte[7:0], last_byte
// out_o     out  valid/ready    cipher_byte[7:0]
// apb       in   psel/penable   cipher_key at byte address 0 (64-bit data)
//
// an item reads S[i], S[j] and the keystream entry one
// after the other, each address set by the previous read, around two swap writes
// the first item after reset or after a last_byte item first runs key scheduling:
// 256 fill writes, then per entry a mix step that swaps S[n] and S[acc]
// reset leaves the key at zero with rekey pending; the table is not cleared
// a finished item waits in the output register while the next is taken

module rc4_stream_cipher #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rc4_in_if.sink                         in_i,
  rc4_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rc4_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rc4_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rc4_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  rc4_pkg::key_t key;

  rc4_key_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  rc4_engine #(
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
